@@ hw/rtl/pie_pkg.sv @@
package pie_pkg;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_DIRECT  = 2'd0,
    MODE_PALETTE = 2'd1,
    MODE_NIBBLE  = 2'd2
  } pie_mode_t;

  localparam logic OPC_PALETTE_WRITE = 1'b0;
  localparam logic OPC_IMAGE         = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DIRECT = 2'd1,
    OP_INDEX  = 2'd2,
    OP_NIBBLE = 2'd3
  } pie_op_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  palette_slot;
    logic [15:0] payload;
    logic        last_in;
  } pie_in_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last_out;
  } pie_out_t;

  typedef struct packed {
    pie_op_t     op;
    logic [7:0]  addr;
    logic [15:0] data;
    logic        last;
  } pie_cmd_t;

endpackage

@@ hw/rtl/pie_queue.sv @@
module pie_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pie_front.sv @@
module pie_front
  import pie_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       take,
  input  pie_in_t    item,
  output logic       cmd_push,
  output pie_cmd_t   cmd
);

  pie_mode_t  mode;
  logic       keep;
  logic [7:0] byte_val;

  assign cfg_ready = 1'b1;
  assign byte_val  = item.payload[7:0];
  assign cmd_push  = take && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DIRECT;
    end else if (cfg_valid) begin
      mode <= pie_mode_t'(cfg_data);
    end
  end

  always_comb begin
    keep      = 1'b1;
    cmd.op    = OP_DIRECT;
    cmd.addr  = byte_val;
    cmd.data  = item.payload;
    cmd.last  = item.last_in;
    if (item.opcode == OPC_PALETTE_WRITE) begin
      cmd.op   = OP_WRITE;
      cmd.addr = item.palette_slot;
      keep     = ({1'b0, item.palette_slot} < 9'(PALETTE_DEPTH));
    end else begin
      unique case (mode)
        MODE_DIRECT: begin
          cmd.op = OP_DIRECT;
        end
        MODE_PALETTE: begin
          if ({1'b0, byte_val} < 9'(PALETTE_DEPTH)) begin
            cmd.op = OP_INDEX;
          end else begin
            cmd.op   = OP_DIRECT;
            cmd.data = '0;
          end
        end
        MODE_NIBBLE: begin
          cmd.op = OP_NIBBLE;
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/pie_back.sv @@
module pie_back
  import pie_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  pie_cmd_t                       cmd,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] res_count,
  output logic                           res_push,
  output pie_out_t                       res
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [15:0] palette [PALETTE_DEPTH];
  logic [15:0] rd_data;
  logic [7:0]  rd_addr;
  logic        phase;
  logic        phase_next;
  logic        head_write;
  logic        head_nibble;
  logic        room;
  logic        go;
  logic        s2_valid;
  logic        s2_use_mem;
  logic [15:0] s2_data;
  logic        s2_last;

  assign head_write  = (cmd.op == OP_WRITE);
  assign head_nibble = (cmd.op == OP_NIBBLE);
  assign room        = ({1'b0, res_count} + (CW + 1)'(s2_valid)) < (CW + 1)'(OUT_DEPTH);
  assign go          = cmd_valid && (head_write || room);
  assign cmd_pop     = go && !(head_nibble && !phase);

  always_comb begin
    rd_addr    = cmd.addr;
    phase_next = phase;
    if (head_nibble) begin
      rd_addr = phase ? {4'h0, cmd.addr[3:0]} : {4'h0, cmd.addr[7:4]};
    end
    if (go && head_nibble) begin
      phase_next = !phase;
    end
  end

  // palette memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (go && head_write) begin
      palette[cmd.addr[AW-1:0]] <= cmd.data;
    end
    rd_data <= palette[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      s2_valid <= go && !head_write;
    end
  end

  always_ff @(posedge clk) begin
    s2_use_mem <= (cmd.op != OP_DIRECT);
    s2_data    <= cmd.data;
    s2_last    <= (head_nibble && !phase) ? 1'b0 : cmd.last;
  end

  assign res_push     = s2_valid;
  assign res.pixel    = s2_use_mem ? rd_data : s2_data;
  assign res.last_out = s2_last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> res_count < CW'(OUT_DEPTH))
    else $error("result pushed into a full queue");

  a_phase_nibble: assert property (@(posedge clk) disable iff (rst)
    phase |-> cmd_valid && head_nibble)
    else $error("second nibble pending without a nibble item at the head");

  a_phase_return: assert property (@(posedge clk) disable iff (rst)
    (go && phase) |=> !phase)
    else $error("nibble phase did not return after second read");

  a_first_nibble_not_last: assert property (@(posedge clk) disable iff (rst)
    (go && head_nibble && !phase) |=> s2_valid && !s2_last)
    else $error("first nibble pixel flagged last");
`endif

endmodule

@@ hw/rtl/palette_image_expander.sv @@
// Expands indexed picture data into ARGB4444 pixels. Items with opcode 0 write
// a palette entry and give no pixel; items with opcode 1 give one pixel in
// direct and 256-colour mode, two (high nibble first) in 16-colour mode and
// none in the unused mode 3. A new item is taken every cycle while the command
// queue is not full; a 16-colour item holds the palette memory's single read
// port for both its reads. Pixels are registered in the back end, then queued.
// The mode register is sampled when an item is taken; no clearing pass is
// needed after reset, but each palette entry must be written before it is used.
module palette_image_expander
  import pie_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  pie_in_t    item,
  output logic       empty,
  input  logic       pop,
  output pie_out_t   result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int CMD_CW = $clog2(CMD_DEPTH + 1);
  localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

  pie_cmd_t            front_cmd;
  pie_cmd_t            head_cmd;
  logic [$bits(pie_cmd_t)-1:0] head_bits;
  logic                cmd_push;
  logic                cmd_pop;
  logic                cmd_empty;
  logic [CMD_CW-1:0]   cmd_count;
  logic                res_push;
  pie_out_t            res;
  logic [$bits(pie_out_t)-1:0] result_bits;
  logic                res_full;
  logic [OUT_CW-1:0]   res_count;

  pie_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .take     (push && !full),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  pie_queue #(
    .DEPTH(CMD_DEPTH),
    .WIDTH($bits(pie_cmd_t))
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(front_cmd),
    .rd_en  (cmd_pop),
    .rd_data(head_bits),
    .empty  (cmd_empty),
    .full   (full),
    .count  (cmd_count)
  );

  assign head_cmd = pie_cmd_t'(head_bits);

  pie_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmd_empty),
    .cmd      (head_cmd),
    .cmd_pop  (cmd_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res      (res)
  );

  pie_queue #(
    .DEPTH(OUT_DEPTH),
    .WIDTH($bits(pie_out_t))
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .rd_en  (pop),
    .rd_data(result_bits),
    .empty  (empty),
    .full   (res_full),
    .count  (res_count)
  );

  assign result = pie_out_t'(result_bits);

`ifndef SYNTHESIS
  a_cmd_count: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= CMD_CW'(CMD_DEPTH))
    else $error("command queue count out of range");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overrun");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");
`endif

endmodule

@@ dv/palette_image_expander_tb.sv @@
`timescale 1ns / 100ps

module palette_image_expander_tb;
  import pie_pkg::*;

  localparam int PALETTE_DEPTH = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  class pixel_book;
    logic [15:0] palette [PALETTE_DEPTH];
    bit written [PALETTE_DEPTH];
    logic [1:0] mode;
    pie_out_t pending_pixels [$];
    int errors;

    function new();
      mode = MODE_DIRECT;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void report(string what);
      $display("ERROR: %s", what);
      errors++;
    endfunction

    function logic [15:0] colour_of(logic [7:0] idx);
      if (idx >= PALETTE_DEPTH) return 16'h0000;
      return palette[idx];
    endfunction

    function void note_item(pie_in_t it);
      pie_out_t px;
      if (it.opcode == OPC_PALETTE_WRITE) begin
        if (it.palette_slot < PALETTE_DEPTH) begin
          palette[it.palette_slot] = it.payload;
          written[it.palette_slot] = 1'b1;
        end
        return;
      end
      case (mode)
        MODE_DIRECT: begin
          px.pixel = it.payload;
          px.last_out = it.last_in;
          pending_pixels.push_back(px);
        end
        MODE_PALETTE: begin
          px.pixel = colour_of(it.payload[7:0]);
          px.last_out = it.last_in;
          pending_pixels.push_back(px);
        end
        MODE_NIBBLE: begin
          // high nibble first, only the second pixel carries the flag
          px.pixel = colour_of({4'h0, it.payload[7:4]});
          px.last_out = 1'b0;
          pending_pixels.push_back(px);
          px.pixel = colour_of({4'h0, it.payload[3:0]});
          px.last_out = it.last_in;
          pending_pixels.push_back(px);
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(pie_out_t got);
      pie_out_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel %h last %b with nothing pending", got.pixel, got.last_out));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel !== want.pixel)
        report($sformatf("pixel %h, expected %h", got.pixel, want.pixel));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %b, expected %b (pixel %h)",
                         got.last_out, want.last_out, want.pixel));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  pie_in_t    item = '0;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic       full;
  logic       empty;
  logic       cfg_ready;
  pie_out_t   result;

  pixel_book book;
  bit running = 1'b0;
  bit calm = 1'b0;
  bit tx_lazy = 1'b1;
  bit rx_lazy = 1'b1;
  int quiet_cycles = 0;

  palette_image_expander #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic pie_in_t item_of(logic op, logic [7:0] slot, logic [15:0] data,
                                      logic last);
    pie_in_t it;
    it.opcode = op;
    it.palette_slot = slot;
    it.payload = data;
    it.last_in = last;
    return it;
  endfunction

  function automatic logic [7:0] written_slot(bit low_only);
    logic [7:0] s;
    do
      s = low_only ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    while (!book.written[s]);
    return s;
  endfunction

  function automatic pie_in_t random_item(logic [1:0] m);
    pie_in_t it;
    logic [7:0] hi;
    logic [7:0] lo;
    it.palette_slot = 8'($urandom_range(0, 255));
    it.payload = 16'($urandom_range(0, 65535));
    it.last_in = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 4) == 0) begin
      it.opcode = OPC_PALETTE_WRITE;
      // keep the 16-colour entries well stocked
      if ($urandom_range(0, 1) == 1) it.palette_slot[7:4] = 4'h0;
    end else begin
      it.opcode = OPC_IMAGE;
      if (m == MODE_PALETTE) begin
        it.payload[7:0] = written_slot(1'b0);
      end else if (m == MODE_NIBBLE) begin
        hi = written_slot(1'b1);
        lo = written_slot(1'b1);
        it.payload[7:0] = {hi[3:0], lo[3:0]};
      end
    end
    return it;
  endfunction

  task automatic push_item(pie_in_t it);
    push <= 1'b1;
    item <= it;
    do @(negedge clk); while (full);
    @(posedge clk);
    book.note_item(it);
  endtask

  task automatic pause_sender();
    if (!calm && tx_lazy && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (book.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    book.mode = m;
  endtask

  always @(negedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("palette_image_expander_tb: done, errors");
      $finish;
    end
  end

  initial begin
    pie_out_t got;
    wait (running);
    forever begin
      if (!calm && rx_lazy && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      pop <= 1'b1;
      do @(negedge clk); while (empty);
      got = result;
      @(posedge clk);
      book.check_pixel(got);
    end
  end

  initial begin
    pie_in_t it;
    logic [1:0] phase_mode;
    int sent;
    int phase_len;
    book = new();
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    running = 1'b1;

    write_mode(MODE_DIRECT);
    push_item(item_of(OPC_PALETTE_WRITE, 8'h00, 16'hFFFF, 1'b1));
    push_item(item_of(OPC_PALETTE_WRITE, 8'hFF, 16'h0000, 1'b0));
    push_item(item_of(OPC_PALETTE_WRITE, 8'h0F, 16'h5A3C, 1'b0));
    pause_sender();
    push_item(item_of(OPC_PALETTE_WRITE, 8'hAA, 16'h1234, 1'b1));
    push_item(item_of(OPC_PALETTE_WRITE, 8'h55, 16'hEDCB, 1'b0));
    push_item(item_of(OPC_IMAGE, 8'hFF, 16'h0000, 1'b0));
    push_item(item_of(OPC_IMAGE, 8'h00, 16'hFFFF, 1'b1));
    settle();
    write_mode(MODE_PALETTE);
    // high byte of the payload must be ignored
    push_item(item_of(OPC_IMAGE, 8'h00, 16'hFF00, 1'b0));
    push_item(item_of(OPC_IMAGE, 8'hFF, 16'h00FF, 1'b1));
    pause_sender();
    push_item(item_of(OPC_IMAGE, 8'h5A, 16'h55AA, 1'b0));
    push_item(item_of(OPC_IMAGE, 8'hA5, 16'hAA55, 1'b1));
    settle();
    write_mode(MODE_NIBBLE);
    push_item(item_of(OPC_IMAGE, 8'h00, 16'hAB0F, 1'b1));
    push_item(item_of(OPC_IMAGE, 8'hFF, 16'h00F0, 1'b0));
    push_item(item_of(OPC_IMAGE, 8'h33, 16'hFFFF, 1'b1));
    push_item(item_of(OPC_PALETTE_WRITE, 8'h01, 16'h0F0F, 1'b0));
    push_item(item_of(OPC_IMAGE, 8'h01, 16'h5510, 1'b0));
    settle();
    write_mode(MODE_UNUSED);
    push_item(item_of(OPC_IMAGE, 8'h12, 16'h1234, 1'b1));
    push_item(item_of(OPC_IMAGE, 8'hFF, 16'hFFFF, 1'b0));
    push_item(item_of(OPC_PALETTE_WRITE, 8'h02, 16'hBEEF, 1'b1));
    push_item(item_of(OPC_IMAGE, 8'h02, 16'h0002, 1'b1));
    settle();

    while (sent < RANDOM_ITEMS) begin
      phase_mode = 2'($urandom_range(0, 3));
      phase_len = $urandom_range(40, 200);
      tx_lazy = ($urandom_range(0, 2) != 0);
      rx_lazy = ($urandom_range(0, 2) != 0);
      write_mode(phase_mode);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        it = random_item(phase_mode);
        push_item(it);
        sent++;
        calm = (sent >= RANDOM_ITEMS - CALM_TAIL);
        if (!calm && $urandom_range(0, 149) == 0)
          settle();
        else
          pause_sender();
      end
      settle();
    end

    if (book.pending_pixels.size() != 0)
      book.report($sformatf("%0d pixels never arrived", book.pending_pixels.size()));
    if (book.errors == 0)
      $display("palette_image_expander_tb: done, clean");
    else
      $display("palette_image_expander_tb: done, errors");
    $finish;
  end

endmodule
